// File: rtl/core/ipdd_pkg.sv
// Shared types, register codes, reset values and the frame check for the IR pulse-distance decoder.
package ipdd_pkg;

  localparam int unsigned CFG_BITS   = 16;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned COUNT_BITS = 6;
  localparam int unsigned CMD_BITS   = 8;

  typedef enum logic [1:0] {
    REG_BIT_THRESHOLD = 2'd0,
    REG_LEADER_MIN    = 2'd1,
    REG_REPEAT_LIMIT  = 2'd2,
    REG_LEADER_MAX    = 2'd3
  } cfg_reg_t;

  localparam logic EVENT_REPEAT = 1'b0;
  localparam logic EVENT_FRAME  = 1'b1;

  localparam logic [CFG_BITS-1:0] RST_BIT_THRESHOLD = 16'd1750;
  localparam logic [CFG_BITS-1:0] RST_LEADER_MIN    = 16'd10000;
  localparam logic [CFG_BITS-1:0] RST_REPEAT_LIMIT  = 16'd12000;
  localparam logic [CFG_BITS-1:0] RST_LEADER_MAX    = 16'd15000;

  // Address and command bytes must each be followed by their bitwise inverse.
  function automatic logic frame_check(input logic [WORD_BITS-1:0] w);
    frame_check = (w[7:0] == ~w[15:8]) && (w[23:16] == ~w[31:24]);
  endfunction

endpackage

// File: rtl/core/ir_pulse_distance_decoder_unit.sv
// IR pulse-distance (NEC style) frame decoder: top level.
// An accepted edge beat is held in the input register; any result it yields is written to the result register.
// Throughput: one edge beat per cycle; the input register feeds the decode logic,
// which writes the result register, so the only stall comes from a held result.
// Reset (rst_n, synchronous, active low) returns the decoder to idle, clears the
// stored edge time and shift register and loads the default timing registers.
module ir_pulse_distance_decoder_unit #(
  parameter int unsigned FRAME_BITS = 32,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [TIMER_BITS-1:0]                 in_edge_time,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_event_kind,
  output logic [ipdd_pkg::CMD_BITS-1:0]         out_command,
  output logic [ipdd_pkg::WORD_BITS-1:0]        out_frame_word,
  output logic                                  out_check_ok,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [ipdd_pkg::CFG_BITS-1:0]         cfg_data
);

  // Comparisons are done at the wider of the timer and register widths.
  localparam int unsigned CMP_W = (TIMER_BITS > ipdd_pkg::CFG_BITS) ?
                                  TIMER_BITS : ipdd_pkg::CFG_BITS;
  // The count holds one more than the number of bits received, so a frame is
  // complete when it reaches one past the frame length.
  localparam logic [ipdd_pkg::COUNT_BITS-1:0] FRAME_DONE =
    ipdd_pkg::COUNT_BITS'(FRAME_BITS + 1);

  // Timing registers.
  logic [ipdd_pkg::CFG_BITS-1:0] bit_threshold_r;
  logic [ipdd_pkg::CFG_BITS-1:0] leader_min_r;
  logic [ipdd_pkg::CFG_BITS-1:0] repeat_limit_r;
  logic [ipdd_pkg::CFG_BITS-1:0] leader_max_r;

  // Input register.
  logic                  s1_valid_r;
  logic [TIMER_BITS-1:0] s1_time_r;
  logic                  s1_go;

  // Decoder state.
  logic [TIMER_BITS-1:0]               last_edge_r, last_edge_nxt;
  logic [ipdd_pkg::COUNT_BITS-1:0]     bit_count_r, bit_count_nxt;
  logic [ipdd_pkg::WORD_BITS-1:0]      bit_shift_r, bit_shift_nxt;

  // Result register.
  logic                                out_valid_r;
  logic                                event_kind_r, event_kind_nxt;
  logic [ipdd_pkg::CMD_BITS-1:0]       command_r, command_nxt;
  logic [ipdd_pkg::WORD_BITS-1:0]      frame_word_r, frame_word_nxt;
  logic                                check_ok_r, check_ok_nxt;
  logic                                emit;

  logic [TIMER_BITS-1:0]               interval;
  logic [CMP_W-1:0]                    ivl_ext;
  logic                                gt_leader_min, lt_leader_min;
  logic                                lt_leader_max, lt_repeat, is_one;
  logic [ipdd_pkg::COUNT_BITS-1:0]     count_inc;

  // The configuration port never stalls; the user must write only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_threshold_r <= ipdd_pkg::RST_BIT_THRESHOLD;
      leader_min_r    <= ipdd_pkg::RST_LEADER_MIN;
      repeat_limit_r  <= ipdd_pkg::RST_REPEAT_LIMIT;
      leader_max_r    <= ipdd_pkg::RST_LEADER_MAX;
    end else if (cfg_valid) begin
      case (ipdd_pkg::cfg_reg_t'(cfg_index))
        ipdd_pkg::REG_BIT_THRESHOLD: bit_threshold_r <= cfg_data;
        ipdd_pkg::REG_LEADER_MIN:    leader_min_r    <= cfg_data;
        ipdd_pkg::REG_REPEAT_LIMIT:  repeat_limit_r  <= cfg_data;
        ipdd_pkg::REG_LEADER_MAX:    leader_max_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The input register moves on whenever the result register can take an
  // answer, whether or not this edge produces one.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_time_r <= in_edge_time;
    end
  end

  // Interval since the previous edge; the subtraction wraps with the timer.
  assign interval      = s1_time_r - last_edge_r;
  assign ivl_ext       = CMP_W'(interval);
  assign gt_leader_min = ivl_ext > CMP_W'(leader_min_r);
  assign lt_leader_min = ivl_ext < CMP_W'(leader_min_r);
  assign lt_leader_max = ivl_ext < CMP_W'(leader_max_r);
  assign lt_repeat     = ivl_ext < CMP_W'(repeat_limit_r);
  assign is_one        = ivl_ext > CMP_W'(bit_threshold_r);
  assign count_inc     = bit_count_r + 1'b1;

  always_comb begin
    last_edge_nxt  = s1_time_r;
    bit_count_nxt  = bit_count_r;
    bit_shift_nxt  = bit_shift_r;
    emit           = 1'b0;
    event_kind_nxt = ipdd_pkg::EVENT_REPEAT;
    command_nxt    = '0;
    frame_word_nxt = '0;
    check_ok_nxt   = 1'b0;
    if (bit_count_r == '0) begin
      // Idle: look for a leader. A short leader is a repeat code, and the
      // stored edge time is kept so the next interval spans it.
      if (gt_leader_min && lt_leader_max) begin
        if (lt_repeat) begin
          emit          = 1'b1;
          last_edge_nxt = last_edge_r;
        end else begin
          bit_count_nxt = {{(ipdd_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
          bit_shift_nxt = '0;
        end
      end
    end else if (lt_leader_min) begin
      // Data bit: the long spacing reads as one, shifted in at the bottom.
      bit_shift_nxt = {bit_shift_r[ipdd_pkg::WORD_BITS-2:0], is_one};
      if (count_inc >= FRAME_DONE) begin
        emit           = 1'b1;
        event_kind_nxt = ipdd_pkg::EVENT_FRAME;
        command_nxt    = bit_shift_nxt[ipdd_pkg::CMD_BITS-1:0];
        frame_word_nxt = bit_shift_nxt;
        check_ok_nxt   = ipdd_pkg::frame_check(bit_shift_nxt);
        bit_count_nxt  = '0;
      end else begin
        bit_count_nxt  = count_inc;
      end
    end else begin
      // An over-long gap abandons the frame; this edge does not start one.
      bit_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      bit_count_r <= '0;
      bit_shift_r <= '0;
    end else if (s1_go) begin
      last_edge_r <= last_edge_nxt;
      bit_count_r <= bit_count_nxt;
      bit_shift_r <= bit_shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      event_kind_r <= event_kind_nxt;
      command_r    <= command_nxt;
      frame_word_r <= frame_word_nxt;
      check_ok_r   <= check_ok_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = event_kind_r;
  assign out_command    = command_r;
  assign out_frame_word = frame_word_r;
  assign out_check_ok   = check_ok_r;

endmodule
